/* design/pbrc_pkg.sv */
// shared constants, codes and control types for the proximity blink rate controller
`default_nettype none

package pbrc_pkg;

	localparam int ELAPSED_BITS = 10;
	localparam int UPD_BITS     = 13;
	localparam int UPD_INT_BITS = 12;
	localparam int CFG_IDX_BITS = 3;

	localparam int RST_MIN_DIST   = 10;
	localparam int RST_MAX_DIST   = 100;
	localparam int RST_SHORT_PER  = 10;
	localparam int RST_LONG_PER   = 1000;
	localparam int RST_UPD_INT    = 500;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MIN_DIST  = 3'd0,
		REG_MAX_DIST  = 3'd1,
		REG_SHORT_PER = 3'd2,
		REG_LONG_PER  = 3'd3,
		REG_UPD_INT   = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		DIV_MAP = 2'd0,
		DIV_UPD = 2'd1,
		DIV_BLK = 2'd2
	} div_op_t;

	typedef struct packed {
		logic    capture;
		logic    mul_num;
		logic    mul_lim;
		logic    map_decide;
		logic    upd_check;
		logic    led_decide;
		logic    div_start;
		logic    div_commit;
		div_op_t div_op;
		logic    load_out;
	} pbrc_cmd_t;

	typedef struct packed {
		logic map_div;
		logic upd_div;
		logic blk_div;
		logic div_done;
	} pbrc_stat_t;

endpackage

`default_nettype wire

/* design/pbrc_if.sv */
// channel interfaces: tick items in, result items out, register writes
`default_nettype none

interface pbrc_tick_if
	import pbrc_pkg::*;
	#(parameter int DIST_BITS = 9);
	logic                    valid;
	logic                    ready;
	logic [ELAPSED_BITS-1:0] elapsed_ms;
	logic [DIST_BITS-1:0]    distance_cm;
	logic                    distance_valid;

	modport source (output valid, elapsed_ms, distance_cm, distance_valid, input ready);
	modport sink (input valid, elapsed_ms, distance_cm, distance_valid, output ready);
endinterface

interface pbrc_result_if #(parameter int DIST_BITS = 9, parameter int PERIOD_BITS = 12);
	logic                   valid;
	logic                   ready;
	logic                   led_on;
	logic [DIST_BITS-1:0]   shown_distance;
	logic [PERIOD_BITS-1:0] shown_period;

	modport source (output valid, led_on, shown_distance, shown_period, input ready);
	modport sink (input valid, led_on, shown_distance, shown_period, output ready);
endinterface

interface pbrc_cfg_if
	import pbrc_pkg::*;
	#(parameter int DATA_BITS = 12);
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [DATA_BITS-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* design/pbrc_div.sv */
// restoring serial divider, one quotient bit per cycle
`default_nettype none

module pbrc_div #(
	parameter int DVD_BITS = 21,
	parameter int DVS_BITS = 12
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [DVD_BITS-1:0] dividend,
	input  wire logic [DVS_BITS-1:0] divisor,
	output logic                     done,
	output logic [DVD_BITS-1:0]      quot,
	output logic [DVS_BITS-1:0]      rem
);

	localparam int CNT_BITS = $clog2(DVD_BITS + 1);

	logic                busy_q;
	logic                done_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [DVS_BITS-1:0] rem_q;
	logic [DVS_BITS-1:0] dvs_q;
	logic [DVD_BITS-1:0] dq_q;

	logic [DVS_BITS:0] trial;
	logic [DVS_BITS:0] sub;
	logic              fits;

	always_comb begin
		trial = {rem_q, dq_q[DVD_BITS-1]};
		sub   = trial - {1'b0, dvs_q};
		fits  = ~sub[DVS_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_BITS'(DVD_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? sub[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
			dq_q  <= {dq_q[DVD_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = dq_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

/* design/pbrc_dp.sv */
// datapath: registers, period mapping, timers, led decision and result register
`default_nettype none

module pbrc_dp
	import pbrc_pkg::*;
#(
	parameter int DIST_BITS   = 9,
	parameter int PERIOD_BITS = 12,
	parameter int TIMER_BITS  = 16,
	parameter int CFG_BITS    = 12
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
	input  wire logic [CFG_BITS-1:0]     cfg_data,
	input  wire logic [ELAPSED_BITS-1:0] in_elapsed,
	input  wire logic [DIST_BITS-1:0]    in_distance,
	input  wire logic                    in_dist_valid,
	input  wire pbrc_cmd_t               cmd,
	output pbrc_stat_t                   stat,
	output logic                         out_led,
	output logic [DIST_BITS-1:0]         out_distance,
	output logic [PERIOD_BITS-1:0]       out_period
);

	localparam int NUM_BITS = DIST_BITS + PERIOD_BITS + 2;
	localparam int MAG_BITS = DIST_BITS + PERIOD_BITS;
	localparam int DVD_A    = (MAG_BITS > TIMER_BITS) ? MAG_BITS : TIMER_BITS;
	localparam int DVD_BITS = (DVD_A > UPD_BITS) ? DVD_A : UPD_BITS;
	localparam int DVS_A    = (DIST_BITS > PERIOD_BITS) ? DIST_BITS : PERIOD_BITS;
	localparam int DVS_BITS = (DVS_A > UPD_INT_BITS) ? DVS_A : UPD_INT_BITS;
	localparam int CMP_BITS = (TIMER_BITS > PERIOD_BITS) ? TIMER_BITS : PERIOD_BITS;

	// configuration
	logic [DIST_BITS-1:0]    min_dist_q;
	logic [DIST_BITS-1:0]    max_dist_q;
	logic [PERIOD_BITS-1:0]  short_per_q;
	logic [PERIOD_BITS-1:0]  long_per_q;
	logic [UPD_INT_BITS-1:0] upd_int_q;

	// item and intermediate values
	logic [ELAPSED_BITS-1:0]    elapsed_q;
	logic [DIST_BITS-1:0]       raw_q;
	logic signed [NUM_BITS-1:0] num_q;
	logic signed [NUM_BITS-1:0] lim_q;
	logic [PERIOD_BITS-1:0]     period_q;

	// block state
	logic [UPD_BITS-1:0]    upd_timer_q;
	logic [TIMER_BITS-1:0]  blink_q;
	logic [DIST_BITS-1:0]   held_dist_q;
	logic [PERIOD_BITS-1:0] held_per_q;
	logic                   toggle_q;
	logic                   led_q;

	// result register
	logic                   out_led_q;
	logic [DIST_BITS-1:0]   out_dist_q;
	logic [PERIOD_BITS-1:0] out_per_q;

	logic signed [DIST_BITS:0]   den_s;
	logic signed [PERIOD_BITS:0] diff_s;
	logic signed [DIST_BITS:0]   rel_s;
	logic [DIST_BITS-1:0]        clamped;
	logic                        den_empty;
	logic                        num_gt;
	logic [PERIOD_BITS-1:0]      map_direct;
	logic [TIMER_BITS:0]         blink_sum;
	logic                        upd_hit;
	logic                        between;
	logic                        blk_ge;
	logic [DVD_BITS-1:0]         dvd;
	logic [DVS_BITS-1:0]         dvs;
	logic                        div_done;
	logic [DVD_BITS-1:0]         div_quot;
	logic [DVS_BITS-1:0]         div_rem;

	always_comb begin
		den_s  = $signed({1'b0, max_dist_q}) - $signed({1'b0, min_dist_q});
		diff_s = $signed({1'b0, long_per_q}) - $signed({1'b0, short_per_q});
		rel_s  = $signed({1'b0, raw_q}) - $signed({1'b0, min_dist_q});

		if (raw_q > max_dist_q)
			clamped = max_dist_q;
		else if (raw_q < min_dist_q)
			clamped = min_dist_q;
		else
			clamped = raw_q;

		den_empty  = den_s[DIST_BITS] || (den_s == '0);
		num_gt     = num_q > lim_q;
		map_direct = (!den_empty && num_gt) ? long_per_q : short_per_q;

		blink_sum = {1'b0, blink_q} + (TIMER_BITS + 1)'(elapsed_q);
		upd_hit   = upd_timer_q >= UPD_BITS'(upd_int_q);
		between   = (held_dist_q > min_dist_q) && (held_dist_q < max_dist_q);
		blk_ge    = CMP_BITS'(blink_q) >= CMP_BITS'(held_per_q);

		stat.map_div  = !den_empty && !num_gt && !num_q[NUM_BITS-1];
		stat.upd_div  = upd_hit && (upd_int_q != '0);
		stat.blk_div  = between && blk_ge && (held_per_q != '0);
		stat.div_done = div_done;

		unique case (cmd.div_op)
			DIV_MAP: begin
				dvd = DVD_BITS'(num_q[MAG_BITS-1:0]);
				dvs = DVS_BITS'(den_s[DIST_BITS-1:0]);
			end
			DIV_UPD: begin
				dvd = DVD_BITS'(upd_timer_q);
				dvs = DVS_BITS'(upd_int_q);
			end
			DIV_BLK: begin
				dvd = DVD_BITS'(blink_q);
				dvs = DVS_BITS'(held_per_q);
			end
			default: begin
				dvd = '0;
				dvs = '0;
			end
		endcase
	end

	pbrc_div #(
		.DVD_BITS(DVD_BITS),
		.DVS_BITS(DVS_BITS)
	) u_pbrc_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_dist_q  <= DIST_BITS'(RST_MIN_DIST);
			max_dist_q  <= DIST_BITS'(RST_MAX_DIST);
			short_per_q <= PERIOD_BITS'(RST_SHORT_PER);
			long_per_q  <= PERIOD_BITS'(RST_LONG_PER);
			upd_int_q   <= UPD_INT_BITS'(RST_UPD_INT);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MIN_DIST:  min_dist_q  <= cfg_data[DIST_BITS-1:0];
				REG_MAX_DIST:  max_dist_q  <= cfg_data[DIST_BITS-1:0];
				REG_SHORT_PER: short_per_q <= cfg_data[PERIOD_BITS-1:0];
				REG_LONG_PER:  long_per_q  <= cfg_data[PERIOD_BITS-1:0];
				REG_UPD_INT:   upd_int_q   <= cfg_data[UPD_INT_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upd_timer_q <= '0;
			blink_q     <= '0;
			held_dist_q <= '0;
			held_per_q  <= '0;
			toggle_q    <= 1'b0;
			led_q       <= 1'b0;
		end else begin
			if (cmd.mul_num) begin
				upd_timer_q <= upd_timer_q + UPD_BITS'(elapsed_q);
				// blink timer sticks at all ones
				blink_q <= blink_sum[TIMER_BITS] ? '1 : blink_sum[TIMER_BITS-1:0];
			end
			if (cmd.upd_check && upd_hit) begin
				held_dist_q <= clamped;
				held_per_q  <= period_q;
				if (upd_int_q == '0)
					upd_timer_q <= '0;
			end
			if (cmd.led_decide) begin
				if (held_dist_q <= min_dist_q) begin
					led_q <= 1'b1;
				end else if (held_dist_q >= max_dist_q) begin
					led_q <= 1'b0;
				end else if (blk_ge) begin
					led_q    <= toggle_q;
					toggle_q <= ~toggle_q;
					if (held_per_q == '0)
						blink_q <= '0;
				end
			end
			if (cmd.div_commit) begin
				unique case (cmd.div_op)
					DIV_UPD: upd_timer_q <= UPD_BITS'(div_rem);
					DIV_BLK: blink_q     <= TIMER_BITS'(div_rem);
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			elapsed_q <= in_elapsed;
			raw_q     <= in_dist_valid ? in_distance : max_dist_q;
		end
		if (cmd.mul_num)
			num_q <= rel_s * diff_s;
		if (cmd.mul_lim)
			lim_q <= diff_s * den_s;
		if (cmd.map_decide && !stat.map_div)
			period_q <= map_direct;
		if (cmd.div_commit && cmd.div_op == DIV_MAP)
			period_q <= short_per_q + PERIOD_BITS'(div_quot);
		if (cmd.load_out) begin
			out_led_q  <= led_q;
			out_dist_q <= held_dist_q;
			out_per_q  <= held_per_q;
		end
	end

	assign out_led      = out_led_q;
	assign out_distance = out_dist_q;
	assign out_period   = out_per_q;

endmodule

`default_nettype wire

/* design/pbrc_ctrl.sv */
// controller: sequences one tick through the datapath and owns the result handshake
`default_nettype none

module pbrc_ctrl
	import pbrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       tick_valid,
	output logic            tick_ready,
	output logic            result_valid,
	input  wire logic       result_ready,
	input  wire pbrc_stat_t stat,
	output pbrc_cmd_t       cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_LIM,
		S_MAP,
		S_MAPDIV,
		S_UPD,
		S_UPDDIV,
		S_LED,
		S_BLKDIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one taken in the same cycle
			if (state_q == S_OUT && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && result_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (tick_valid)
						state_q <= S_MUL;
				end
				S_MUL: state_q <= S_LIM;
				S_LIM: state_q <= S_MAP;
				S_MAP: state_q <= stat.map_div ? S_MAPDIV : S_UPD;
				S_MAPDIV: begin
					if (stat.div_done)
						state_q <= S_UPD;
				end
				S_UPD: state_q <= stat.upd_div ? S_UPDDIV : S_LED;
				S_UPDDIV: begin
					if (stat.div_done)
						state_q <= S_LED;
				end
				S_LED: state_q <= stat.blk_div ? S_BLKDIV : S_OUT;
				S_BLKDIV: begin
					if (stat.div_done)
						state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.div_op = DIV_MAP;
		unique case (state_q)
			S_IDLE: cmd.capture = tick_valid;
			S_MUL:  cmd.mul_num = 1'b1;
			S_LIM:  cmd.mul_lim = 1'b1;
			S_MAP: begin
				cmd.map_decide = 1'b1;
				cmd.div_start  = stat.map_div;
			end
			S_MAPDIV: cmd.div_commit = stat.div_done;
			S_UPD: begin
				cmd.upd_check = 1'b1;
				cmd.div_op    = DIV_UPD;
				cmd.div_start = stat.upd_div;
			end
			S_UPDDIV: begin
				cmd.div_op     = DIV_UPD;
				cmd.div_commit = stat.div_done;
			end
			S_LED: begin
				cmd.led_decide = 1'b1;
				cmd.div_op     = DIV_BLK;
				cmd.div_start  = stat.blk_div;
			end
			S_BLKDIV: begin
				cmd.div_op     = DIV_BLK;
				cmd.div_commit = stat.div_done;
			end
			S_OUT: cmd.load_out = out_free;
			default: ;
		endcase
	end

	assign tick_ready   = (state_q == S_IDLE);
	assign result_valid = out_valid_q;

endmodule

`default_nettype wire

/* design/proximity_blink_rate_controller.sv */
// top level of the proximity blink rate controller
`default_nettype none

// One tick item (elapsed ms, distance in cm, valid flag) gives one result item
// (led level, latched distance, latched period). Ticks are handled one at a
// time by a controller stepping a datapath around a single shared restoring
// divider that produces one quotient bit per cycle. Its dividend is DW bits
// wide, where DW is the largest of DIST_BITS+PERIOD_BITS, TIMER_BITS and 13
// (21 by default). A tick uses the divider only where it needs to: one division
// maps an in-range distance onto the period, one wraps the update timer when it
// expires, one wraps the blink timer when it reaches the period. The result
// sits in an output register, so the next tick is taken while a result still
// waits. Register writes are accepted in every cycle and must only come while
// no tick is in flight.
module proximity_blink_rate_controller
	import pbrc_pkg::*;
#(
	parameter int DIST_BITS   = 9,
	parameter int PERIOD_BITS = 12,
	parameter int TIMER_BITS  = 16
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	pbrc_tick_if.sink     tick,
	pbrc_result_if.source result,
	pbrc_cfg_if.sink      cfg
);

	localparam int CFG_A    = (DIST_BITS > PERIOD_BITS) ? DIST_BITS : PERIOD_BITS;
	localparam int CFG_BITS = (CFG_A > UPD_INT_BITS) ? CFG_A : UPD_INT_BITS;

	pbrc_cmd_t  cmd;
	pbrc_stat_t stat;

	assign cfg.ready = 1'b1;

	pbrc_ctrl u_pbrc_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick_valid   (tick.valid),
		.tick_ready   (tick.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	pbrc_dp #(
		.DIST_BITS   (DIST_BITS),
		.PERIOD_BITS (PERIOD_BITS),
		.TIMER_BITS  (TIMER_BITS),
		.CFG_BITS    (CFG_BITS)
	) u_pbrc_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.in_elapsed    (tick.elapsed_ms),
		.in_distance   (tick.distance_cm),
		.in_dist_valid (tick.distance_valid),
		.cmd           (cmd),
		.stat          (stat),
		.out_led       (result.led_on),
		.out_distance  (result.shown_distance),
		.out_period    (result.shown_period)
	);

endmodule

`default_nettype wire

/* design/pbrc_checker.sv */
// port-level checks of the controller, bound to the top level
`default_nettype none

module pbrc_checker #(
	parameter int DIST_BITS   = 9,
	parameter int PERIOD_BITS = 12
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   tick_valid,
	input wire logic                   tick_ready,
	input wire logic                   result_valid,
	input wire logic                   result_ready,
	input wire logic                   led_on,
	input wire logic [DIST_BITS-1:0]   shown_distance,
	input wire logic [PERIOD_BITS-1:0] shown_period
);

	// a stalled result keeps its value
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(led_on)
			&& $stable(shown_distance) && $stable(shown_period))
		else $error("stalled result changed");

	// result valid only drops after it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(result_valid) |-> $past(result_ready))
		else $error("result withdrawn without handshake");

	// a tick is worked on before the next one is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		tick_valid && tick_ready |=> !tick_ready)
		else $error("tick taken while another is in progress");

	// a new result only appears at the end of a tick's processing
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(!tick_ready))
		else $error("result appeared while idle");

endmodule

bind proximity_blink_rate_controller pbrc_checker #(
	.DIST_BITS   (DIST_BITS),
	.PERIOD_BITS (PERIOD_BITS)
) u_pbrc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.tick_valid     (tick.valid),
	.tick_ready     (tick.ready),
	.result_valid   (result.valid),
	.result_ready   (result.ready),
	.led_on         (result.led_on),
	.shown_distance (result.shown_distance),
	.shown_period   (result.shown_period)
);

`default_nettype wire

/* test/proximity_blink_rate_controller_tb.sv */
// testbench for the proximity blink rate controller: predicted ticks checked against results
module proximity_blink_rate_controller_tb import pbrc_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIST_W        = 9;
	localparam int PERIOD_W      = 12;
	localparam int TIMER_W       = 16;
	localparam int CFG_DATA_W    = 12;
	localparam int CFG_REG_COUNT = 5;
	localparam int unsigned TIMER_MAX = (1 << TIMER_W) - 1;
	localparam int TICK_LATENCY  = 80;
	localparam int CYCLE_LIMIT   = 1_200_000;
	localparam int RANDOM_PHASES = 10;
	localparam int PHASE_TICKS   = 86;

	typedef struct packed {
		logic                led_on;
		logic [DIST_W-1:0]   shown_distance;
		logic [PERIOD_W-1:0] shown_period;
	} blink_result_t;

	logic clk;
	logic arst_n;

	pbrc_tick_if #(.DIST_BITS(DIST_W)) tick_ch ();
	pbrc_result_if #(.DIST_BITS(DIST_W), .PERIOD_BITS(PERIOD_W)) result_ch ();
	pbrc_cfg_if #(.DATA_BITS(CFG_DATA_W)) cfg_ch ();

	proximity_blink_rate_controller #(
		.DIST_BITS(DIST_W),
		.PERIOD_BITS(PERIOD_W),
		.TIMER_BITS(TIMER_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.tick(tick_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	// predictor copy of the registers and the state
	logic [DIST_W-1:0]   cfg_min_dist = DIST_W'(RST_MIN_DIST);
	logic [DIST_W-1:0]   cfg_max_dist = DIST_W'(RST_MAX_DIST);
	logic [PERIOD_W-1:0] cfg_short_per = PERIOD_W'(RST_SHORT_PER);
	logic [PERIOD_W-1:0] cfg_long_per = PERIOD_W'(RST_LONG_PER);
	logic [UPD_INT_BITS-1:0] cfg_upd_int = UPD_INT_BITS'(RST_UPD_INT);
	logic [UPD_BITS-1:0] upd_timer = '0;
	logic [TIMER_W-1:0]  blink_tmr = '0;
	logic [DIST_W-1:0]   held_dist = '0;
	logic [PERIOD_W-1:0] held_per = '0;
	logic                toggle_phase = 1'b0;
	logic                led_level = 1'b0;

	blink_result_t pending_results[$];

	int cycle_count = 0;
	int error_count = 0;
	int ticks_sent = 0;
	int results_checked = 0;
	int settings_applied = 0;
	int toggles_predicted = 0;
	int latches_predicted = 0;
	logic steady_flow = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_results.size());
			$display("proximity_blink_rate_controller test failed");
			$finish;
		end
	end

	// truncated linear map of the distance onto the period range
	function automatic logic [PERIOD_W-1:0] mapped_period(logic [DIST_W-1:0] d);
		longint lo, hi, s, l, den, num;
		lo = cfg_min_dist;
		hi = cfg_max_dist;
		s = cfg_short_per;
		l = cfg_long_per;
		den = hi - lo;
		if (den <= 0)
			return cfg_short_per;
		num = (longint'(d) - lo) * (l - s);
		if (num > (l - s) * den)
			return cfg_long_per;
		if (num < 0)
			return cfg_short_per;
		return PERIOD_W'(s + num / den);
	endfunction

	function automatic blink_result_t next_blink_result(logic [ELAPSED_BITS-1:0] elapsed,
			logic [DIST_W-1:0] dist_cm, logic dvalid);
		logic [DIST_W-1:0]   raw, clamped;
		logic [PERIOD_W-1:0] period;
		int unsigned         blink_sum;
		blink_result_t       res;
		raw = dvalid ? dist_cm : cfg_max_dist;
		if (raw > cfg_max_dist)
			clamped = cfg_max_dist;
		else if (raw < cfg_min_dist)
			clamped = cfg_min_dist;
		else
			clamped = raw;
		period = mapped_period(raw);
		upd_timer = upd_timer + elapsed;
		blink_sum = blink_tmr + elapsed;
		if (blink_sum > TIMER_MAX)
			blink_sum = TIMER_MAX;
		if (upd_timer >= cfg_upd_int) begin
			upd_timer = (cfg_upd_int == 0) ? '0 : upd_timer % cfg_upd_int;
			held_dist = clamped;
			held_per = period;
			latches_predicted++;
		end
		if (held_dist <= cfg_min_dist) begin
			led_level = 1'b1;
		end else if (held_dist >= cfg_max_dist) begin
			led_level = 1'b0;
		end else if (blink_sum >= held_per) begin
			blink_sum = (held_per == 0) ? 0 : blink_sum % held_per;
			led_level = toggle_phase;
			toggle_phase = !toggle_phase;
			toggles_predicted++;
		end
		blink_tmr = blink_sum[TIMER_W-1:0];
		res.led_on = led_level;
		res.shown_distance = held_dist;
		res.shown_period = held_per;
		return res;
	endfunction

	task automatic report_error(input string msg);
		$display("MISMATCH cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	function automatic int pick_gap();
		int r;
		if (steady_flow)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// result side: random stalls on ready
	initial begin : result_sink
		int  run_left;
		logic level;
		run_left = 0;
		level = 1'b0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (steady_flow) begin
				result_ch.ready = 1'b1;
			end else begin
				if (run_left == 0) begin
					level = !level;
					run_left = level ? $urandom_range(1, 20) : pick_gap() + 1;
				end
				run_left--;
				result_ch.ready = level;
			end
		end
	end

	always @(posedge clk) begin : check_results
		blink_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (pending_results.size() == 0) begin
				report_error("result item with no tick pending");
			end else begin
				want = pending_results.pop_front();
				if (result_ch.led_on !== want.led_on)
					report_error($sformatf("led_on got %0b want %0b",
						result_ch.led_on, want.led_on));
				if (result_ch.shown_distance !== want.shown_distance)
					report_error($sformatf("shown_distance got %0d want %0d",
						result_ch.shown_distance, want.shown_distance));
				if (result_ch.shown_period !== want.shown_period)
					report_error($sformatf("shown_period got %0d want %0d",
						result_ch.shown_period, want.shown_period));
			end
			results_checked++;
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_tick(input logic [ELAPSED_BITS-1:0] elapsed,
			input logic [DIST_W-1:0] dist_cm, input logic dvalid);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			tick_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid = 1'b1;
		tick_ch.elapsed_ms = elapsed;
		tick_ch.distance_cm = dist_cm;
		tick_ch.distance_valid = dvalid;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
		pending_results.push_back(next_blink_result(elapsed, dist_cm, dvalid));
		ticks_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		tick_ch.valid = 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data = val;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			REG_MIN_DIST:  cfg_min_dist = val[DIST_W-1:0];
			REG_MAX_DIST:  cfg_max_dist = val[DIST_W-1:0];
			REG_SHORT_PER: cfg_short_per = val[PERIOD_W-1:0];
			REG_LONG_PER:  cfg_long_per = val[PERIOD_W-1:0];
			REG_UPD_INT:   cfg_upd_int = val[UPD_INT_BITS-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// distance registers get junk in the unused upper data bits
	task automatic apply_config(input int mn, input int mx, input int s, input int l,
			input int u);
		logic [CFG_DATA_W-DIST_W-1:0] junk;
		wait_drain();
		junk = (CFG_DATA_W - DIST_W)'($urandom_range(0, (1 << (CFG_DATA_W - DIST_W)) - 1));
		write_reg(REG_MIN_DIST, {junk, DIST_W'(mn)});
		junk = (CFG_DATA_W - DIST_W)'($urandom_range(0, (1 << (CFG_DATA_W - DIST_W)) - 1));
		write_reg(REG_MAX_DIST, {junk, DIST_W'(mx)});
		write_reg(REG_SHORT_PER, CFG_DATA_W'(s));
		write_reg(REG_LONG_PER, CFG_DATA_W'(l));
		write_reg(REG_UPD_INT, CFG_DATA_W'(u));
		settings_applied++;
	endtask

	task automatic test_reset_values();
		send_tick(0, 0, 1'b0);
		send_tick(1023, 511, 1'b1);
		send_tick(500, 50, 1'b1);
		send_tick(20, 5, 1'b1);
	endtask

	task automatic test_field_extremes();
		apply_config(0, 511, 1, 4095, 1);
		send_tick(0, 0, 1'b1);
		send_tick(1023, 511, 1'b1);
		send_tick(1023, 0, 1'b1);
		send_tick(0, 511, 1'b0);
		send_tick(341, 170, 1'b1);
		send_tick(682, 341, 1'b1);
		// reversed periods at the top of the register ranges
		apply_config(510, 511, 4095, 1, 4095);
		send_tick(1023, 511, 1'b1);
		send_tick(1023, 510, 1'b1);
		send_tick(1023, 0, 1'b0);
		send_tick(1023, 300, 1'b1);
	endtask

	task automatic test_open_cases();
		// empty distance range, then equal bounds
		apply_config(200, 100, 50, 900, 1);
		send_tick(10, 150, 1'b1);
		send_tick(10, 50, 1'b1);
		send_tick(10, 300, 1'b0);
		apply_config(100, 100, 70, 900, 1);
		send_tick(10, 100, 1'b1);
		send_tick(10, 99, 1'b1);
		// latch on every tick
		apply_config(10, 300, 20, 400, 0);
		send_tick(5, 150, 1'b1);
		send_tick(0, 151, 1'b1);
		send_tick(17, 152, 1'b1);
		// zero period while blinking toggles every tick
		apply_config(0, 511, 0, 0, 1);
		send_tick(1, 200, 1'b1);
		send_tick(1, 200, 1'b1);
		send_tick(0, 201, 1'b1);
		// reversed periods inside the range
		apply_config(0, 511, 3000, 100, 1);
		send_tick(100, 255, 1'b1);
		send_tick(1000, 255, 1'b1);
		// an unused register index is ignored
		wait_drain();
		write_reg(CFG_IDX_BITS'($urandom_range(CFG_REG_COUNT, (1 << CFG_IDX_BITS) - 1)),
			CFG_DATA_W'($urandom));
		send_tick(300, 255, 1'b1);
	endtask

	task automatic test_timer_saturation();
		int i;
		// steady on keeps the blink timer from wrapping until it saturates
		apply_config(10, 100, 4000, 4095, 1);
		for (i = 0; i < 66; i++)
			send_tick(1023, 5, 1'b1);
		for (i = 0; i < 3; i++)
			send_tick(1023, 50, 1'b1);
	endtask

	task automatic test_random_traffic();
		int phase, i, r, mn, mx, s, l, u;
		logic [ELAPSED_BITS-1:0] elapsed;
		logic [DIST_W-1:0] dist_cm;
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			if (phase % 4 == 0) begin
				case (phase / 4)
					0: apply_config(0, 511, 1, 4095, 4095);
					1: apply_config(0, 1, 4095, 1, 1);
					default: apply_config(250, 251, 1, 4095, 7);
				endcase
			end else begin
				mn = $urandom_range(0, 500);
				mx = $urandom_range(mn + 1, 511);
				if ($urandom_range(0, 9) < 7) begin
					s = $urandom_range(1, 300);
					l = $urandom_range(s, 2000);
				end else begin
					s = $urandom_range(1, 4095);
					l = $urandom_range(1, 4095);
				end
				u = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 64)
					: $urandom_range(1, 4095);
				apply_config(mn, mx, s, l, u);
			end
			steady_flow = (phase == 3);
			for (i = 0; i < PHASE_TICKS; i++) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					elapsed = ELAPSED_BITS'($urandom_range(0, 63));
				else if (r < 70)
					elapsed = ELAPSED_BITS'($urandom_range(0, 1023));
				else if (r < 85)
					elapsed = ELAPSED_BITS'($urandom_range(0, 7));
				else if (r < 92)
					elapsed = '0;
				else
					elapsed = '1;
				r = $urandom_range(0, 99);
				if (r < 60) begin
					dist_cm = DIST_W'($urandom_range(cfg_min_dist, cfg_max_dist));
				end else if (r < 90) begin
					dist_cm = DIST_W'($urandom_range(0, 511));
				end else begin
					case ($urandom_range(0, 3))
						0: dist_cm = cfg_min_dist;
						1: dist_cm = cfg_max_dist;
						2: dist_cm = cfg_min_dist + 1'b1;
						default: dist_cm = cfg_max_dist - 1'b1;
					endcase
				end
				send_tick(elapsed, dist_cm, $urandom_range(0, 9) != 0);
				// hold the sender off until everything has come back
				if (i == PHASE_TICKS / 2 && $urandom_range(0, 1) != 0)
					wait_drain();
			end
			steady_flow = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		tick_ch.valid = 1'b0;
		tick_ch.elapsed_ms = '0;
		tick_ch.distance_cm = '0;
		tick_ch.distance_valid = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_values();
		test_field_extremes();
		test_open_cases();
		test_timer_saturation();
		test_random_traffic();

		wait_drain();
		repeat (TICK_LATENCY) @(negedge clk);
		$display("%0d ticks sent under %0d register settings, %0d results checked",
			ticks_sent, settings_applied, results_checked);
		$display("%0d led toggles and %0d latches predicted, %0d mismatches",
			toggles_predicted, latches_predicted, error_count);
		if (error_count == 0)
			$display("proximity_blink_rate_controller test passed");
		else
			$display("proximity_blink_rate_controller test failed");
		$finish;
	end

endmodule

/* proximity_blink_rate_controller.f */
design/pbrc_pkg.sv
design/pbrc_if.sv
design/pbrc_div.sv
design/pbrc_dp.sv
design/pbrc_ctrl.sv
design/proximity_blink_rate_controller.sv
design/pbrc_checker.sv
test/proximity_blink_rate_controller_tb.sv
